// ===== rtl/wrs_pkg.sv =====
// ----------------------------------------------------------------------------
// wrs_pkg: shared types and constants of the weighted random selector
// Field widths of the item and result beats, operation and status codes,
// parameter defaults and the command/status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package wrs_pkg;

  // Beat field widths
  localparam int OPERATION_W = 1;
  localparam int WEIGHT_W    = 16;
  localparam int UNIFORM_W   = 32;
  localparam int STATUS_W    = 2;
  localparam int INDEX_W     = 4;
  localparam int TOTAL_W     = 20;
  localparam int COUNT_W     = 5;

  // Parameter defaults
  localparam int MAX_ENTRIES_DEF  = 16;
  localparam int WEIGHT_BITS_DEF  = 16;
  localparam int UNIFORM_BITS_DEF = 32;

  typedef enum logic [OPERATION_W-1:0] {
    OP_ADD  = 1'b0,
    OP_DRAW = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;     // latch the accepted item
    logic do_add;      // append an entry (or flag full)
    logic draw_empty;  // draw on an empty table
    logic start_draw;  // form the scaled target, start the table walk
    logic walk;        // compare one table entry
    logic emit;        // load the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic op_draw;
    logic table_empty;
    logic walk_done;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/wrs_req_if.sv =====
// ----------------------------------------------------------------------------
// wrs_req_if: item channel of the weighted random selector
// valid/ready handshake carrying one add or draw item per beat.
// ----------------------------------------------------------------------------
interface wrs_req_if;
  logic                             valid;
  logic                             ready;
  logic [wrs_pkg::OPERATION_W-1:0]  operation;
  logic [wrs_pkg::WEIGHT_W-1:0]     weight;
  logic [wrs_pkg::UNIFORM_W-1:0]    uniform_value;

  modport source (output valid, output operation, output weight, output uniform_value,
                  input ready);
  modport sink   (input valid, input operation, input weight, input uniform_value,
                  output ready);
endinterface

// ===== rtl/wrs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// wrs_rsp_if: result channel of the weighted random selector
// valid/ready handshake carrying one result per beat.
// ----------------------------------------------------------------------------
interface wrs_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [wrs_pkg::STATUS_W-1:0]   status;
  logic [wrs_pkg::INDEX_W-1:0]    selected_index;
  logic [wrs_pkg::TOTAL_W-1:0]    weight_total;
  logic [wrs_pkg::COUNT_W-1:0]    entry_count;

  modport source (output valid, output status, output selected_index,
                  output weight_total, output entry_count, input ready);
  modport sink   (input valid, input status, input selected_index,
                  input weight_total, input entry_count, output ready);
endinterface

// ===== rtl/wrs_ram.sv =====
// ----------------------------------------------------------------------------
// wrs_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data. No reset.
// ----------------------------------------------------------------------------
module wrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/wrs_datapath.sv =====
// ----------------------------------------------------------------------------
// wrs_datapath: table, totals, comparator and result register
// Holds the cumulative weight table in RAM, the entry count and running
// total, the scaled draw target and the walk pointers, and the result beat.
// ----------------------------------------------------------------------------
module wrs_datapath #(
  parameter int MAX_ENTRIES  = wrs_pkg::MAX_ENTRIES_DEF,
  parameter int WEIGHT_BITS  = wrs_pkg::WEIGHT_BITS_DEF,
  parameter int UNIFORM_BITS = wrs_pkg::UNIFORM_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  wrs_pkg::cmd_t                    cmd,
  output wrs_pkg::sts_t                    sts,
  input  logic [wrs_pkg::OPERATION_W-1:0]  operation,
  input  logic [wrs_pkg::WEIGHT_W-1:0]     weight,
  input  logic [wrs_pkg::UNIFORM_W-1:0]    uniform_value,
  wrs_rsp_if.source                        rsp
);

  // Only the low bits of the weight field that the configuration allows
  localparam int WB     = (WEIGHT_BITS < wrs_pkg::WEIGHT_W) ? WEIGHT_BITS : wrs_pkg::WEIGHT_W;
  localparam int IDX_W  = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int TOT_W  = WB + IDX_W;
  localparam int PROD_W = UNIFORM_BITS + TOT_W;
  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(MAX_ENTRIES - 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_ENTRIES);

  wrs_pkg::op_t         op;
  logic [WB-1:0]        wgt;
  logic [UNIFORM_BITS-1:0] uval;
  logic [CNT_W-1:0]     count;
  logic [TOT_W-1:0]     total;
  logic [PROD_W-1:0]    prod;
  logic [IDX_W-1:0]     walk_idx;
  logic [IDX_W-1:0]     cmp_idx;
  wrs_pkg::status_t     res_status;
  logic [IDX_W-1:0]     res_index;

  logic [TOT_W-1:0]     sum;
  logic [TOT_W-1:0]     rdata;
  logic                 table_full;
  logic                 table_empty;
  logic                 hit;
  logic                 is_last;
  logic                 walk_done;
  logic                 out_free;
  logic                 ram_we;
  logic [IDX_W-1:0]     walk_idx_next;

  // Table status and comparator
  assign sum         = total + TOT_W'(wgt);
  assign table_full  = (count == FULL_COUNT);
  assign table_empty = (count == '0);
  // U * total <= cum * 2^UNIFORM_BITS
  assign hit         = ({rdata, {UNIFORM_BITS{1'b0}}} >= prod);
  assign is_last     = ((CNT_W'(cmp_idx) + CNT_W'(1)) == count);
  assign walk_done   = hit || is_last;
  assign out_free    = !rsp.valid || rsp.ready;
  assign ram_we      = cmd.do_add && !table_full;
  assign walk_idx_next = (walk_idx == LAST_IDX) ? walk_idx : walk_idx + 1'b1;

  assign sts.op_draw     = (op == wrs_pkg::OP_DRAW);
  assign sts.table_empty = table_empty;
  assign sts.walk_done   = walk_done;
  assign sts.out_free    = out_free;

  // Cumulative weight table
  wrs_ram #(
    .WIDTH (TOT_W),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[IDX_W-1:0]),
    .wdata (sum),
    .raddr (walk_idx),
    .rdata (rdata)
  );

  // Item, walk and result registers
  always_ff @(posedge clk) begin
    cmp_idx <= walk_idx;
    if (cmd.capture) begin
      op       <= wrs_pkg::op_t'(operation);
      wgt      <= weight[WB-1:0];
      uval     <= uniform_value[UNIFORM_BITS-1:0];
      walk_idx <= '0;
    end
    if (cmd.do_add) begin
      if (table_full) begin
        res_status <= wrs_pkg::ST_FULL;
        res_index  <= '0;
      end else begin
        res_status <= wrs_pkg::ST_OK;
        res_index  <= count[IDX_W-1:0];
      end
    end
    if (cmd.draw_empty) begin
      res_status <= wrs_pkg::ST_EMPTY;
      res_index  <= '0;
    end
    if (cmd.start_draw) begin
      prod       <= uval * total;
      walk_idx   <= walk_idx_next;
      res_status <= wrs_pkg::ST_OK;
    end
    if (cmd.walk) begin
      walk_idx <= walk_idx_next;
      if (walk_done) begin
        res_index <= cmp_idx;
      end
    end
  end

  // Entry count and running total
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      total <= '0;
    end else if (ram_we) begin
      count <= count + CNT_W'(1);
      total <= sum;
    end
  end

  // Result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp.status         <= res_status;
      rsp.selected_index <= wrs_pkg::INDEX_W'(res_index);
      rsp.weight_total   <= wrs_pkg::TOTAL_W'(total);
      rsp.entry_count    <= wrs_pkg::COUNT_W'(count);
    end
  end

`ifndef NO_ASSERTIONS
  // A successful add grows the table by exactly one entry
  a_add_count: assert property (@(posedge clk) disable iff (rst)
    (!rst && cmd.do_add && !table_full) |=> (count == $past(count) + CNT_W'(1)))
    else $error("entry count did not advance on add");

  // The total only moves on an add
  a_total_hold: assert property (@(posedge clk) disable iff (rst)
    (!rst && !cmd.do_add) |=> (total == $past(total)))
    else $error("running total changed outside an add");

  // A result is never loaded over one still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> out_free)
    else $error("result register overwritten");

  // The walk only inspects stored entries
  a_walk_range: assert property (@(posedge clk) disable iff (rst)
    cmd.walk |-> (CNT_W'(cmp_idx) < count))
    else $error("table walk past the stored entries");
`endif

endmodule

// ===== rtl/wrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// wrs_ctrl: sequencing of the weighted random selector
// Accepts an item, runs an add, a table walk or an empty-table draw in the
// datapath, then hands the result to the result register once it is free.
// ----------------------------------------------------------------------------
module wrs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          valid,
  output logic          ready,
  input  wrs_pkg::sts_t sts,
  output wrs_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (valid && ready) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!sts.op_draw) begin
          cmd.do_add = 1'b1;
          state_next = S_EMIT;
        end else if (sts.table_empty) begin
          cmd.draw_empty = 1'b1;
          state_next     = S_EMIT;
        end else begin
          cmd.start_draw = 1'b1;
          state_next     = S_WALK;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and registered ready
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ready <= 1'b0;
    end else begin
      state <= state_next;
      ready <= (state_next == S_IDLE);
    end
  end

endmodule

// ===== rtl/weighted_random_selector.sv =====
// An add beat appends an entry and returns its index; a draw beat returns the
// first entry whose cumulative weight reaches U times the total, scaled by
// 2^UNIFORM_BITS. Each result also carries the total weight and entry count.
// One item is in flight at a time. An add goes from acceptance through the
// execute and emit states to its result beat; a draw first multiplies U by
// the total, then a single comparator walks the cumulative table one RAM
// read per cycle and stops at the selected entry. The next item can be taken
// in the cycle after a result is loaded, even while that result waits. The
// table needs no clearing after reset: only entries already written are read.
// ----------------------------------------------------------------------------
// weighted_random_selector: roulette-wheel selector over weighted entries
// Top level joining the controller and the datapath to the item and result
// channels.
// ----------------------------------------------------------------------------
module weighted_random_selector #(
  parameter int MAX_ENTRIES  = wrs_pkg::MAX_ENTRIES_DEF,
  parameter int WEIGHT_BITS  = wrs_pkg::WEIGHT_BITS_DEF,
  parameter int UNIFORM_BITS = wrs_pkg::UNIFORM_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  wrs_req_if.sink   req,
  wrs_rsp_if.source rsp
);

  wrs_pkg::cmd_t cmd;
  wrs_pkg::sts_t sts;
  logic          ready;

  assign req.ready = ready;

  // Sequencer
  wrs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .valid (req.valid),
    .ready (ready),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Table and arithmetic
  wrs_datapath #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .WEIGHT_BITS  (WEIGHT_BITS),
    .UNIFORM_BITS (UNIFORM_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .operation     (req.operation),
    .weight        (req.weight),
    .uniform_value (req.uniform_value),
    .rsp           (rsp)
  );

endmodule

// ===== bench/wrs_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrs_tb_pkg: result ledger for the weighted random selector bench
// Keeps a bit-exact copy of the cumulative weight table, works out the result
// of every accepted item beat and checks each result beat against the oldest
// one still outstanding.
// ----------------------------------------------------------------------------
package wrs_tb_pkg;
  import wrs_pkg::*;

  localparam int TABLE_DEPTH = MAX_ENTRIES_DEF;

  typedef struct {
    status_t            status;
    logic [INDEX_W-1:0] index;
    logic [TOTAL_W-1:0] total;
    logic [COUNT_W-1:0] count;
  } pick_t;

  class wheel_scoreboard;
    logic [TOTAL_W-1:0] cum_weight [TABLE_DEPTH];
    int                 stored;
    logic [TOTAL_W-1:0] total;
    pick_t              expected_picks [$];
    int                 mismatches;
    int                 n_add, n_full, n_draw, n_empty, n_results;
    int                 drawn_hist [TABLE_DEPTH];

    function new();
      stored     = 0;
      total      = '0;
      mismatches = 0;
      n_add      = 0;
      n_full     = 0;
      n_draw     = 0;
      n_empty    = 0;
      n_results  = 0;
      foreach (drawn_hist[i]) drawn_hist[i] = 0;
    endfunction

    function int outstanding();
      return expected_picks.size();
    endfunction

    // Table update and roulette pick for one item beat
    function pick_t predict_selection(op_t op, logic [WEIGHT_W-1:0] w,
                                      logic [UNIFORM_W-1:0] u);
      pick_t       res;
      logic [63:0] target;
      res.status = ST_OK;
      res.index  = '0;
      if (op == OP_ADD) begin
        if (stored >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          res.index          = INDEX_W'(stored);
          total              = total + TOTAL_W'(w);
          cum_weight[stored] = total;
          stored++;
        end
      end else if (stored == 0) begin
        res.status = ST_EMPTY;
      end else begin
        // first entry with U * total <= cum * 2^32; last entry if none
        target    = 64'(u) * 64'(total);
        res.index = INDEX_W'(stored - 1);
        for (int i = stored - 1; i >= 0; i--) begin
          if (target <= {12'd0, cum_weight[i], 32'd0}) res.index = INDEX_W'(i);
        end
      end
      res.total = total;
      res.count = COUNT_W'(stored);
      return res;
    endfunction

    function void note_item(op_t op, logic [WEIGHT_W-1:0] w, logic [UNIFORM_W-1:0] u);
      pick_t res;
      res = predict_selection(op, w, u);
      expected_picks.insert(expected_picks.size(), res);
      if (op == OP_ADD) begin
        n_add++;
        if (res.status == ST_FULL) n_full++;
      end else begin
        n_draw++;
        if (res.status == ST_EMPTY) n_empty++;
        else drawn_hist[res.index]++;
      end
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [INDEX_W-1:0] idx,
                               logic [TOTAL_W-1:0] tot, logic [COUNT_W-1:0] cnt);
      pick_t want;
      n_results++;
      if (expected_picks.size() == 0) begin
        $error("result beat with nothing outstanding: status %0d index %0d", st, idx);
        mismatches++;
        return;
      end
      want = expected_picks.pop_front();
      if (st !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, st);
        mismatches++;
      end
      if (idx !== want.index) begin
        $error("selected_index: expected %0d, got %0d", want.index, idx);
        mismatches++;
      end
      if (tot !== want.total) begin
        $error("weight_total: expected %0d, got %0d", want.total, tot);
        mismatches++;
      end
      if (cnt !== want.count) begin
        $error("entry_count: expected %0d, got %0d", want.count, cnt);
        mismatches++;
      end
    endfunction
  endclass

endpackage

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: bench for the weighted random selector
// A directed run through the empty table, zero weights and exact boundary
// draws, then random add and draw beats with random idling on both channels.
// The table fills once and stays full, so later adds check the full status.
// ----------------------------------------------------------------------------
module tb;
  import wrs_pkg::*;
  import wrs_tb_pkg::*;

  localparam int ITEMS_RANDOM = 650;
  localparam int DRAIN_CYCLES = 24;

  logic            clk;
  logic            rst = 1'b1;
  logic            no_idle = 1'b0;
  int              boundary_draws = 0;
  wheel_scoreboard sb;

  wrs_req_if req_ch ();
  wrs_rsp_if rsp_ch ();

  weighted_random_selector dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // Present one item beat after a random gap; valid only drops when a gap follows
  task automatic send_item(op_t op, logic [WEIGHT_W-1:0] w, logic [UNIFORM_W-1:0] u);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.operation     <= op;
    req_ch.weight        <= w;
    req_ch.uniform_value <= u;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sb.note_item(op, w, u);
  endtask

  // Result side: random stall after each beat, then hold ready until the next one
  initial begin : result_sink
    int stall;
    rsp_ch.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      sb.check_result(rsp_ch.status, rsp_ch.selected_index,
                      rsp_ch.weight_total, rsp_ch.entry_count);
    end
  end

  initial begin : stimulus
    logic [WEIGHT_W-1:0]  w;
    logic [UNIFORM_W-1:0] u;
    logic [63:0]          cut;
    int                   slot;
    int                   distinct;
    bit                   filling;

    sb                   = new();
    req_ch.valid         = 1'b0;
    req_ch.operation     = OP_ADD;
    req_ch.weight        = '0;
    req_ch.uniform_value = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, zero weights, extreme weights and exact ties
    send_item(OP_DRAW, '0, '0);
    send_item(OP_DRAW, '1, '1);
    send_item(OP_ADD,  '0, '1);
    send_item(OP_DRAW, '1, '0);                // all weights zero
    send_item(OP_DRAW, '0, '1);
    send_item(OP_ADD,  '0, '0);
    send_item(OP_DRAW, '0, '1);
    send_item(OP_ADD,  '1, '0);                // heaviest weight
    send_item(OP_DRAW, '0, '0);                // zero-weight entry wins on equality
    send_item(OP_DRAW, '0, 32'd1);
    send_item(OP_DRAW, '0, '1);
    send_item(OP_ADD,  16'd1, '0);
    send_item(OP_DRAW, '0, 32'hFFFF_0000);     // exact tie on the heavy entry
    send_item(OP_DRAW, '0, 32'hFFFF_0001);     // just past it
    send_item(OP_ADD,  16'hAAAA, 32'h5555_5555);
    send_item(OP_ADD,  16'h5555, 32'hAAAA_AAAA);
    send_item(OP_DRAW, 16'hFFFF, 32'h8000_0000);
    send_item(OP_DRAW, 16'h0000, 32'h7FFF_FFFF);

    // Random: fill the table among draws, then draws with the odd refused add
    for (int n = 0; n < ITEMS_RANDOM; n++) begin
      if (n % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      filling = (sb.stored < TABLE_DEPTH);
      if ($urandom_range(0, filling ? 3 : 11) == 0) begin
        case ($urandom_range(0, 7))
          0:       w = '0;
          1:       w = '1;
          2:       w = WEIGHT_W'($urandom_range(1, 15));
          default: w = WEIGHT_W'($urandom);
        endcase
        send_item(OP_ADD, w, $urandom);
      end else begin
        case ($urandom_range(0, 5))
          0: u = '0;
          1: u = '1;
          2, 3: begin
            // aim at the edge between two entries, one either side of it
            slot = $urandom_range(0, sb.stored - 1);
            cut  = (sb.total == '0) ? 64'd0 :
                   {12'd0, sb.cum_weight[slot], 32'd0} / 64'(sb.total);
            cut  = cut + 64'($urandom_range(0, 2));
            if (cut != 64'd0) cut = cut - 64'd1;
            u    = (cut > 64'hFFFF_FFFF) ? '1 : cut[UNIFORM_W-1:0];
            boundary_draws++;
          end
          default: u = $urandom;
        endcase
        send_item(OP_DRAW, WEIGHT_W'($urandom), u);
      end
    end
    req_ch.valid <= 1'b0;
    no_idle = 1'b0;

    // Drain, then allow for a late spurious beat
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    distinct = 0;
    foreach (sb.drawn_hist[i]) if (sb.drawn_hist[i] > 0) distinct++;
    $display("Checked %0d results: %0d adds (%0d refused on a full table), %0d draws",
             sb.n_results, sb.n_add, sb.n_full, sb.n_draw);
    $display("%0d draws on an empty table, %0d aimed at entry edges, %0d of %0d entries drawn",
             sb.n_empty, boundary_draws, distinct, TABLE_DEPTH);
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== weighted_random_selector.f =====
rtl/wrs_pkg.sv
rtl/wrs_req_if.sv
rtl/wrs_rsp_if.sv
rtl/wrs_ram.sv
rtl/wrs_datapath.sv
rtl/wrs_ctrl.sv
rtl/weighted_random_selector.sv
bench/wrs_tb_pkg.sv
bench/tb.sv
